>>> hdl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern search block.
`default_nettype none
package wbps_pkg;

   // Pattern byte value that matches any data byte ('?').
   localparam logic [7:0] WILDCARD = 8'h3F;

   // Width of the configuration write data and of each pattern register.
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_INDEX_BITS = 3;

   // Width of the pattern length register and of every length value.
   localparam int LEN_BITS = 6;

   // Number of 64-bit pattern registers and bytes per register.
   localparam int PATTERN_REGS = 4;
   localparam int BYTES_PER_REG = 8;

   // Width of the result offset port.
   localparam int RESULT_OFFSET_BITS = 32;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_0_7    = 3'd0,
      CSR_PATTERN_8_15   = 3'd1,
      CSR_PATTERN_16_23  = 3'd2,
      CSR_PATTERN_24_31  = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4
   } csr_index_type;

endpackage
`default_nettype wire

>>> hdl/wbps_csr.sv
// Configuration registers: pattern bytes and the clamped pattern length.
`default_nettype none
module wbps_csr #(
   parameter int PATTERN_MAX = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [wbps_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [wbps_pkg::CSR_DATA_BITS-1:0]     csr_write_data,
   output logic      [PATTERN_MAX*8-1:0]               pattern,
   output logic      [wbps_pkg::LEN_BITS-1:0]          used_length
);
   import wbps_pkg::*;

   localparam int ALL_BYTES = PATTERN_REGS * BYTES_PER_REG;
   localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(PATTERN_MAX);
   localparam logic [LEN_BITS-1:0] MIN_LEN = LEN_BITS'(1);

   logic [PATTERN_REGS*CSR_DATA_BITS-1:0] pattern_ff;
   logic [PATTERN_REGS*CSR_DATA_BITS-1:0] pattern_in;
   logic [LEN_BITS-1:0]                   length_ff;
   logic [LEN_BITS-1:0]                   length_in;

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PATTERN_0_7:    pattern_in[0*CSR_DATA_BITS +: CSR_DATA_BITS] = csr_write_data;
            CSR_PATTERN_8_15:   pattern_in[1*CSR_DATA_BITS +: CSR_DATA_BITS] = csr_write_data;
            CSR_PATTERN_16_23:  pattern_in[2*CSR_DATA_BITS +: CSR_DATA_BITS] = csr_write_data;
            CSR_PATTERN_24_31:  pattern_in[3*CSR_DATA_BITS +: CSR_DATA_BITS] = csr_write_data;
            CSR_PATTERN_LENGTH: length_in = csr_write_data[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= MIN_LEN;
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
      end
   end

   // Only the first PATTERN_MAX bytes can ever take part in a compare.
   assign pattern = pattern_ff[PATTERN_MAX*8-1:0];

   // A length of zero acts as one; a length above the window acts as the window size.
   always_comb begin
      if (length_ff == '0) begin
         used_length = MIN_LEN;
      end else if (length_ff > MAX_LEN) begin
         used_length = MAX_LEN;
      end else begin
         used_length = length_ff;
      end
   end

   // ALL_BYTES bounds the legal window size.
   if (PATTERN_MAX > ALL_BYTES) begin : g_bad_size
      $error("PATTERN_MAX exceeds the pattern register space");
   end

endmodule
`default_nettype wire

>>> hdl/wbps_match.sv
// Masked wildcard compare of the pattern against the newest window bytes.
`default_nettype none
module wbps_match #(
   parameter int PATTERN_MAX = 32
) (
   input  wire logic [PATTERN_MAX*8-1:0]        pattern,
   input  wire logic [wbps_pkg::LEN_BITS-1:0]   used_length,
   input  wire logic [PATTERN_MAX*8-1:0]        window,
   output logic                                 hit
);
   import wbps_pkg::*;

   localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(PATTERN_MAX);

   logic [PATTERN_MAX*8-1:0] reversed;
   logic [PATTERN_MAX*8-1:0] aligned;
   logic [LEN_BITS-1:0]      shift_bytes;
   logic [PATTERN_MAX-1:0]   byte_ok;

   // Window byte j (j = 0 is the newest) must match pattern byte n-1-j.
   // Reversing the pattern and shifting it down by PATTERN_MAX-n bytes
   // lines every pattern byte up with its window byte.
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         reversed[8*k +: 8] = pattern[8*(PATTERN_MAX-1-k) +: 8];
      end
      shift_bytes = MAX_LEN - used_length;
      aligned     = reversed >> {shift_bytes, 3'b000};
      for (int j = 0; j < PATTERN_MAX; j++) begin
         byte_ok[j] = (LEN_BITS'(j) >= used_length)
                   || (aligned[8*j +: 8] == WILDCARD)
                   || (aligned[8*j +: 8] == window[8*j +: 8]);
      end
   end

   assign hit = &byte_ok;

endmodule
`default_nettype wire

>>> hdl/wildcard_byte_pattern_search.sv
// Top level of the streaming wildcard byte pattern search.
// The block scans a region one byte per transfer and reports the first offset where
// the configured pattern (up to PATTERN_MAX bytes, 0x3F matching any byte) lies wholly
// inside the region. It returns exactly one result per region: found set with the start
// offset at the first match, or found clear with offset zero at the last byte when
// nothing matched; bytes after a match only wait for the last byte, which resets the
// region state. The block takes one byte every cycle unless a full result register is
// refused. A byte is held in an input register, then a single pass shifts it into a
// PATTERN_MAX-byte window, compares the whole window against the pattern in parallel and
// loads the result register when the byte leaves the input register; the result can be
// transferred once the result register holds it. The result register drains while new
// bytes keep arriving; only a full result register whose transfer is refused stalls the
// input. The offset saturates at the smaller of 2^OFFSET_BITS-1 and 2^32-1. The user
// must write pattern registers through the csr port only while no byte is in flight;
// the block does not enforce this. Writes apply from the next byte on.
`default_nettype none
module wildcard_byte_pattern_search #(
   parameter int PATTERN_MAX = 32,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_ready,
   input  wire logic [7:0]                                req_data_byte,
   input  wire logic                                      req_last_byte,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_ready,
   output logic                                           rsp_found,
   output logic      [wbps_pkg::RESULT_OFFSET_BITS-1:0]   rsp_match_offset,
   input  wire logic                                      csr_write_enable,
   input  wire logic [wbps_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  wire logic [wbps_pkg::CSR_DATA_BITS-1:0]        csr_write_data
);
   import wbps_pkg::*;

   // The byte counter has one bit more than the offset so it can tell when
   // the offset limit has been passed.
   localparam int COUNT_BITS = OFFSET_BITS + 1;
   localparam int OUT_BITS = (OFFSET_BITS < RESULT_OFFSET_BITS) ? OFFSET_BITS
                                                                : RESULT_OFFSET_BITS;
   localparam logic [COUNT_BITS-1:0] OFFSET_LIMIT = (COUNT_BITS'(1) << OUT_BITS) - COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [PATTERN_MAX*8-1:0] pattern;
   logic [LEN_BITS-1:0]      used_length;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff,  in_data_in;
   logic       in_last_ff,  in_last_in;

   // Region state.
   logic [PATTERN_MAX*8-1:0] window_ff, window_in;
   logic [COUNT_BITS-1:0]    seen_ff,   seen_in;
   logic                     reported_ff, reported_in;

   // Result register.
   logic                          out_valid_ff, out_valid_in;
   logic                          out_found_ff, out_found_in;
   logic [RESULT_OFFSET_BITS-1:0] out_offset_ff, out_offset_in;

   logic                     advance;
   logic [PATTERN_MAX*8-1:0] window_shift;
   logic [COUNT_BITS-1:0]    seen_next;
   logic [COUNT_BITS-1:0]    raw_offset;
   logic [COUNT_BITS-1:0]    sat_offset;
   logic                     window_hit;
   logic                     active;
   logic                     emit_found;
   logic                     emit_miss;

   wbps_csr #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pattern          (pattern),
      .used_length      (used_length)
   );

   // The held byte moves on whenever the result register is empty or is being
   // drained in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_last_in  = in_last_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data_byte;
         in_last_in  = req_last_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // The newest byte enters at the low end of the window.
   assign window_shift = {window_ff[PATTERN_MAX*8-9:0], in_data_ff};
   assign seen_next    = (seen_ff == COUNT_MAX) ? seen_ff : seen_ff + COUNT_BITS'(1);

   wbps_match #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_match (
      .pattern     (pattern),
      .used_length (used_length),
      .window      (window_shift),
      .hit         (window_hit)
   );

   // Once a match has been reported, the rest of the region is ignored.
   assign active     = !reported_ff;
   assign emit_found = active && window_hit && (seen_next >= COUNT_BITS'(used_length));
   assign emit_miss  = active && !emit_found && in_last_ff;

   assign raw_offset = seen_next - COUNT_BITS'(used_length);
   assign sat_offset = (raw_offset > OFFSET_LIMIT) ? OFFSET_LIMIT : raw_offset;

   always_comb begin
      window_in   = window_ff;
      seen_in     = seen_ff;
      reported_in = reported_ff;
      if (advance) begin
         if (in_last_ff) begin
            // End of region: the window needs no clear since the count guards it.
            seen_in     = '0;
            reported_in = 1'b0;
         end else if (active) begin
            window_in   = window_shift;
            seen_in     = seen_next;
            reported_in = emit_found;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_found_in  = out_found_ff;
      out_offset_in = out_offset_ff;
      if (advance && (emit_found || emit_miss)) begin
         out_valid_in  = 1'b1;
         out_found_in  = emit_found;
         out_offset_in = emit_found ? RESULT_OFFSET_BITS'(sat_offset) : '0;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         seen_ff      <= '0;
         reported_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         seen_ff      <= seen_in;
         reported_ff  <= reported_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff    <= in_data_in;
      in_last_ff    <= in_last_in;
      window_ff     <= window_in;
      out_found_ff  <= out_found_in;
      out_offset_ff <= out_offset_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_found        = out_found_ff;
   assign rsp_match_offset = out_offset_ff;

   // A reported match always follows at least one counted byte of the region.
   a_reported_has_bytes: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> (seen_ff != '0))
      else $error("match flag set with an empty region count");

   // A no-match result always carries a zero offset.
   a_miss_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_found_ff) |-> (out_offset_ff == '0))
      else $error("no-match result with a nonzero offset");

   // A match in the middle of a region blocks any further result for it.
   a_match_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (advance && emit_found && !in_last_ff) |=> reported_ff)
      else $error("match flag not set after a reported match");

   // Nothing is emitted for a region whose match was already reported.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> !(emit_found || emit_miss))
      else $error("second result generated for one region");

endmodule
`default_nettype wire
